// ----- rtl/core/lmgs_pkg.sv -----
package lmgs_pkg;

    localparam int GRID    = 8;
    localparam int IDX_W   = $clog2(GRID);
    localparam int LEVEL_W = 3;
    localparam int WORD_W  = 2 * GRID;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [IDX_W-1:0]   pixel_line;
        logic [IDX_W-1:0]   scan_column;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]  drive_word;
        logic [IDX_W-1:0]   active_line;
        logic [LEVEL_W-1:0] active_plane;
    } t_out_item;

    // Command from the front end to the pixel store.
    typedef struct packed {
        logic               wr_en;
        logic               clr;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   pix;
        logic [LEVEL_W-1:0] level;
    } t_store_cmd;

endpackage

// ----- rtl/core/lmgs_store.sv -----
module lmgs_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lmgs_pkg::t_store_cmd            i_cmd,
    input  logic [lmgs_pkg::IDX_W-1:0]      i_rd_line,
    input  logic [lmgs_pkg::LEVEL_W-1:0]    i_rd_plane,
    output logic [lmgs_pkg::GRID-1:0]       o_lit
);

    localparam int ROW_W = lmgs_pkg::GRID * lmgs_pkg::LEVEL_W;

    // One row per scan line; an entry without its valid bit reads as level zero.
    logic [ROW_W-1:0]          r_rows  [lmgs_pkg::GRID];
    logic [lmgs_pkg::GRID-1:0] r_valid [lmgs_pkg::GRID];

    logic [ROW_W-1:0]          rd_row;
    logic [lmgs_pkg::GRID-1:0] rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_rows[i_cmd.row][i_cmd.pix*lmgs_pkg::LEVEL_W +: lmgs_pkg::LEVEL_W] <= i_cmd.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < lmgs_pkg::GRID; r++) begin
                r_valid[r] <= '0;
            end
        end else if (i_cmd.clr) begin
            for (int r = 0; r < lmgs_pkg::GRID; r++) begin
                r_valid[r] <= '0;
            end
        end else if (i_cmd.wr_en) begin
            r_valid[i_cmd.row][i_cmd.pix] <= 1'b1;
        end
    end

    assign rd_row   = r_rows[i_rd_line];
    assign rd_valid = r_valid[i_rd_line];

    // Pixel line p lands on bit GRID-1-p.
    always_comb begin
        for (int p = 0; p < lmgs_pkg::GRID; p++) begin
            o_lit[lmgs_pkg::GRID-1-p] = rd_valid[p]
                && (rd_row[p*lmgs_pkg::LEVEL_W +: lmgs_pkg::LEVEL_W] > i_rd_plane);
        end
    end

endmodule

// ----- rtl/core/led_matrix_grayscale_scan.sv -----
// A tick's drive word is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one item per cycle while o_in_stall is low; a tick is one store row read and eight 3-bit compares.
// An output register plus a one-entry skid stage lets input continue while one result waits.
// Reset (i_rst_n low, synchronous): counters to zero, output and skid emptied,
// and all pixel valid bits cleared so every level reads as zero at once; no sweep.
module led_matrix_grayscale_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lmgs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lmgs_pkg::t_out_item o_out_data
);

    logic                           in_xfer;
    logic                           tick;
    lmgs_pkg::t_store_cmd           cmd;
    logic [lmgs_pkg::GRID-1:0]      lit;
    logic [lmgs_pkg::GRID-1:0]      sel_n;
    lmgs_pkg::t_out_item            result;

    logic [lmgs_pkg::IDX_W-1:0]     r_line;
    logic [lmgs_pkg::LEVEL_W-1:0]   r_plane;
    logic                           r_out_valid;
    lmgs_pkg::t_out_item            r_out;
    logic                           r_skid_valid;
    lmgs_pkg::t_out_item            r_skid;

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign tick       = in_xfer && (i_in_data.operation == lmgs_pkg::OP_TICK);

    always_comb begin
        cmd.wr_en = in_xfer && (i_in_data.operation == lmgs_pkg::OP_WRITE);
        cmd.clr   = in_xfer && (i_in_data.operation == lmgs_pkg::OP_CLEAR);
        cmd.row   = i_in_data.scan_column;
        cmd.pix   = i_in_data.pixel_line;
        cmd.level = i_in_data.level;
    end

    lmgs_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_rd_line  (r_line),
        .i_rd_plane (r_plane),
        .o_lit      (lit)
    );

    always_comb begin
        sel_n                = '1;
        sel_n[r_line]        = 1'b0;
        result.drive_word    = {sel_n, lit};
        result.active_line   = r_line;
        result.active_plane  = r_plane;
    end

    // Advance line on every tick, plane when the line wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_plane <= '0;
        end else if (tick) begin
            r_line <= r_line + 1'b1;
            if (r_line == lmgs_pkg::IDX_W'(lmgs_pkg::GRID - 1)) begin
                r_plane <= r_plane + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid  <= r_skid_valid || tick;
            r_skid_valid <= 1'b0;
        end else if (tick) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: refill from skid first, otherwise park a new result in the skid.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (tick) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output is empty");

    a_tick_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_select_matches_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_out_data.drive_word[lmgs_pkg::WORD_W-1:lmgs_pkg::GRID])
            == lmgs_pkg::GRID - 1)
            && !o_out_data.drive_word[lmgs_pkg::GRID + o_out_data.active_line])
        else $error("line select does not match active line");

endmodule
